/* src/dtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_pkg: shared definitions of the transitive closure unit
// Node count, derived widths, command codes and the cell control bundle.
// ----------------------------------------------------------------------------
package dtc_pkg;

    localparam int NODES  = 8;
    localparam int IDX_W  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int NODE_W = 3;
    localparam int CODE_W = 6;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic             clear;
        logic             update;
        logic             shift;
        logic [IDX_W-1:0] pivot_idx;
    } t_cell_ctl;

endpackage

/* src/dtc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_cell: one row of the adjacency matrix
// Holds one row, merges the broadcast pivot row into it when the row reaches
// the pivot node, and hands its row to the previous cell when the ring turns.
// ----------------------------------------------------------------------------
module dtc_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dtc_pkg::t_cell_ctl        i_ctl,
    input  logic [dtc_pkg::NODES-1:0] i_pivot_row,
    input  logic [dtc_pkg::NODES-1:0] i_next_row,
    input  logic [dtc_pkg::NODES-1:0] i_set_bits,
    output logic [dtc_pkg::NODES-1:0] o_row,
    output logic [dtc_pkg::NODES-1:0] o_pass_row
);

    logic [dtc_pkg::NODES-1:0] r_row;
    logic [dtc_pkg::NODES-1:0] n_row;
    logic [dtc_pkg::NODES-1:0] w_merged;

    assign w_merged   = r_row[i_ctl.pivot_idx] ? (r_row | i_pivot_row) : r_row;
    assign o_pass_row = i_ctl.update ? w_merged : r_row;
    assign o_row      = r_row;

    always_comb begin
        if (i_ctl.clear) begin
            n_row = '0;
        end else if (i_ctl.shift) begin
            n_row = i_next_row;
        end else begin
            n_row = r_row | i_set_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

endmodule

/* src/dag_transitive_closure_unit.sv */
`timescale 1ns / 1ps
// Add and clear items are accepted back to back.
// A close item runs NODES closure passes around the ring of cells, then emits
// the closed edges row by row, holding the input stalled until the run ends.
// Synchronous active-low reset empties the matrix and drops any pending edge.
// ----------------------------------------------------------------------------
// dag_transitive_closure_unit: transitive closure of a small directed graph
// Rows of the adjacency matrix sit in a ring of cells that turns once per
// closure pass and once per row during emission of the closed edges.
// ----------------------------------------------------------------------------
module dag_transitive_closure_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_command,
    input  logic [dtc_pkg::NODE_W-1:0] i_source_node,
    input  logic [dtc_pkg::NODE_W-1:0] i_target_node,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [dtc_pkg::CODE_W-1:0] o_edge_code,
    output logic                       o_last_edge
);

    localparam int N  = dtc_pkg::NODES;
    localparam int IW = dtc_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CLOSE = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_pass, n_pass;
    logic [IW-1:0] r_row_cnt, n_row_cnt;
    logic [N-1:0]  r_mask, n_mask;
    logic          r_out_valid;
    logic [dtc_pkg::CODE_W-1:0] r_edge_code;
    logic          r_last_edge;

    dtc_pkg::t_cell_ctl w_ctl;
    logic [N-1:0] w_rows [N];
    logic [N-1:0] w_pass [N];
    logic [N-1:0] w_set  [N];

    logic         w_accept;
    logic         w_add_ok;
    logic [N-1:0] w_remaining;
    logic [N-1:0] w_lowbit;
    logic [N-1:0] w_rest;
    logic [IW-1:0] w_low_idx;
    logic         w_has_rem;
    logic         w_tail_any;
    logic         w_out_free;
    logic         w_emit;
    logic         w_advance;
    logic [dtc_pkg::CODE_W-1:0] w_code;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_add_ok   = ({1'b0, i_source_node} < (dtc_pkg::NODE_W + 1)'(N)) &&
                        ({1'b0, i_target_node} < (dtc_pkg::NODE_W + 1)'(N));
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_remaining = w_rows[0] & ~r_mask;
    assign w_lowbit    = w_remaining & (~w_remaining + N'(1));
    assign w_rest      = w_remaining & ~w_lowbit;
    assign w_has_rem   = |w_remaining;
    assign w_emit      = (r_state == S_EMIT) && w_has_rem && w_out_free;
    assign w_advance   = (r_state == S_EMIT) && (!w_has_rem || (w_emit && !(|w_rest)));

    always_comb begin
        w_low_idx = '0;
        for (int b = N - 1; b >= 0; b--) begin
            if (w_remaining[b]) begin
                w_low_idx = IW'(b);
            end
        end
    end

    always_comb begin
        w_tail_any = 1'b0;
        for (int j = 1; j < N; j++) begin
            if ((IW + 1)'(j) + {1'b0, r_row_cnt} < (IW + 1)'(N)) begin
                w_tail_any = w_tail_any | (|w_rows[j]);
            end
        end
    end

    assign w_code = dtc_pkg::CODE_W'(r_row_cnt) * dtc_pkg::CODE_W'(N)
                  + dtc_pkg::CODE_W'(w_low_idx);

    always_comb begin
        w_ctl.clear     = w_accept && (i_command == dtc_pkg::CMD_CLEAR);
        w_ctl.update    = (r_state == S_CLOSE);
        w_ctl.shift     = (r_state == S_CLOSE) || w_advance;
        w_ctl.pivot_idx = r_pass;
    end

    always_comb begin
        for (int j = 0; j < N; j++) begin
            w_set[j] = '0;
            if (w_accept && (i_command == dtc_pkg::CMD_ADD) && w_add_ok &&
                (i_source_node == dtc_pkg::NODE_W'(j))) begin
                w_set[j] = N'(1) << i_target_node;
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        dtc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_pivot_row (w_rows[0]),
            .i_next_row  (w_pass[(g + 1) % N]),
            .i_set_bits  (w_set[g]),
            .o_row       (w_rows[g]),
            .o_pass_row  (w_pass[g])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_pass    = r_pass;
        n_row_cnt = r_row_cnt;
        n_mask    = r_mask;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_command == dtc_pkg::CMD_CLOSE)) begin
                    n_state = S_CLOSE;
                    n_pass  = '0;
                end
            end
            S_CLOSE: begin
                n_pass = r_pass + IW'(1);
                if (r_pass == IW'(N - 1)) begin
                    n_state   = S_EMIT;
                    n_row_cnt = '0;
                    n_mask    = '0;
                end
            end
            S_EMIT: begin
                if (w_advance) begin
                    n_mask    = '0;
                    n_row_cnt = r_row_cnt + IW'(1);
                    if (r_row_cnt == IW'(N - 1)) begin
                        n_state = S_IDLE;
                    end
                end else if (w_emit) begin
                    n_mask = r_mask | w_lowbit;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= '0;
            r_row_cnt   <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pass    <= n_pass;
            r_row_cnt <= n_row_cnt;
            r_mask    <= n_mask;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_edge_code <= w_code;
            r_last_edge <= !(|w_rest) && !w_tail_any;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_edge_code = r_edge_code;
    assign o_last_edge = r_last_edge;

endmodule

/* src/dtc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_checker: port-level checks of the transitive closure unit
// Watches the handshakes and the busy behavior around a close item.
// ----------------------------------------------------------------------------
module dtc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic [1:0]                 i_command,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [dtc_pkg::CODE_W-1:0] o_edge_code,
    input logic                       o_last_edge
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_edge_code) && $stable(o_last_edge))
        else $error("Stalled output item changed or was dropped.");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_edge |-> o_in_stall)
        else $error("Input taken while an edge run is still being emitted.");

    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command == dtc_pkg::CMD_CLOSE) |=> o_in_stall)
        else $error("Close item did not start a closure run.");

    a_other_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command != dtc_pkg::CMD_CLOSE) |=> !o_in_stall)
        else $error("Add, clear or unused item left the unit busy.");

endmodule

bind dag_transitive_closure_unit dtc_checker u_dtc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_command   (i_command),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_edge_code (o_edge_code),
    .o_last_edge (o_last_edge)
);

/* bench/tb_dag_transitive_closure_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dag_transitive_closure_unit: self-checking bench of the closure unit
// Add, close, clear and unused commands are streamed into the unit under
// bursty valid and patterned output stall. A bit-matrix model of the graph
// computes the expected edge run of every close, and each emitted edge is
// checked against it in order.
// ----------------------------------------------------------------------------
module tb_dag_transitive_closure_unit;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 3 * dtc_pkg::NODES + 16;
    localparam int PRINT_LIMIT  = 100;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]                 command;
        logic [dtc_pkg::NODE_W-1:0] source_node;
        logic [dtc_pkg::NODE_W-1:0] target_node;
        bit                         wait_drain;
    } t_graph_item;

    typedef struct {
        logic [dtc_pkg::CODE_W-1:0] edge_code;
        logic                       last_edge;
    } t_closed_edge;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} t_stall_mode;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_in_valid    = 1'b0;
    logic [1:0]                 i_command     = dtc_pkg::CMD_ADD;
    logic [dtc_pkg::NODE_W-1:0] i_source_node = '0;
    logic [dtc_pkg::NODE_W-1:0] i_target_node = '0;
    logic                       i_out_stall   = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [dtc_pkg::CODE_W-1:0] o_edge_code;
    logic                       o_last_edge;

    logic [dtc_pkg::NODES-1:0] reach_rows [dtc_pkg::NODES];
    t_graph_item               pending_items [$];
    t_closed_edge              closure_edges_due [$];

    int          fail_count  = 0;
    int          cycle_count = 0;
    bit          in_taken    = 1'b0;
    int          gap_left    = 0;
    int          burst_left  = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_mode_left = 0;
    int          long_stall_left = 0;

    dag_transitive_closure_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_source_node (i_source_node),
        .i_target_node (i_target_node),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_edge_code   (o_edge_code),
        .o_last_edge   (o_last_edge)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
        end
    endtask

    task automatic push_item(input logic [1:0] command, input int source_node,
                             input int target_node);
        t_graph_item item;
        item.command     = command;
        item.source_node = dtc_pkg::NODE_W'(source_node);
        item.target_node = dtc_pkg::NODE_W'(target_node);
        item.wait_drain  = 1'b0;
        pending_items    = {pending_items, item};
    endtask

    task automatic push_drain_point();
        t_graph_item item;
        item.command     = CMD_UNUSED;
        item.source_node = '0;
        item.target_node = '0;
        item.wait_drain  = 1'b1;
        pending_items    = {pending_items, item};
    endtask

    // Applies one accepted item to the graph and queues the edges a close emits.
    task automatic apply_graph_item(input logic [1:0] command,
                                    input logic [dtc_pkg::NODE_W-1:0] source_node,
                                    input logic [dtc_pkg::NODE_W-1:0] target_node);
        t_closed_edge result;
        int total_edges;
        int emitted;
        total_edges = 0;
        emitted     = 0;
        case (command)
            dtc_pkg::CMD_ADD: begin
                if (int'(source_node) < dtc_pkg::NODES &&
                    int'(target_node) < dtc_pkg::NODES) begin
                    reach_rows[source_node][target_node] = 1'b1;
                end
            end
            dtc_pkg::CMD_CLEAR: begin
                foreach (reach_rows[r]) reach_rows[r] = '0;
            end
            dtc_pkg::CMD_CLOSE: begin
                for (int k = 0; k < dtc_pkg::NODES; k++) begin
                    for (int r = 0; r < dtc_pkg::NODES; r++) begin
                        if (reach_rows[r][k]) begin
                            reach_rows[r] = reach_rows[r] | reach_rows[k];
                        end
                    end
                end
                foreach (reach_rows[r]) total_edges += $countones(reach_rows[r]);
                for (int s = 0; s < dtc_pkg::NODES; s++) begin
                    for (int d = 0; d < dtc_pkg::NODES; d++) begin
                        if (reach_rows[s][d]) begin
                            emitted++;
                            result.edge_code = dtc_pkg::CODE_W'(s * dtc_pkg::NODES + d);
                            result.last_edge = (emitted == total_edges);
                            closure_edges_due = {closure_edges_due, result};
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_closed_edge want;
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            in_taken <= i_rst_n && i_in_valid && !o_in_stall;
            if (i_rst_n) begin
                if (i_in_valid && !o_in_stall) begin
                    apply_graph_item(i_command, i_source_node, i_target_node);
                end
                if (o_out_valid && !i_out_stall) begin
                    if (closure_edges_due.size() == 0) begin
                        report_mismatch($sformatf("unexpected edge code %0d last %0d",
                                                  o_edge_code, o_last_edge));
                    end else begin
                        want = closure_edges_due.pop_front();
                        if (o_edge_code !== want.edge_code) begin
                            report_mismatch($sformatf("edge code %0d, expected %0d",
                                                      o_edge_code, want.edge_code));
                        end
                        if (o_last_edge !== want.last_edge) begin
                            report_mismatch($sformatf("last flag %0d on edge %0d, expected %0d",
                                                      o_last_edge, want.edge_code,
                                                      want.last_edge));
                        end
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        t_graph_item next_item;
        logic next_valid;
        bit   load;
        next_valid = i_in_valid;
        load       = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && in_taken) begin
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    while (pending_items.size() > 0 && pending_items[0].wait_drain
                           && closure_edges_due.size() == 0) begin
                        void'(pending_items.pop_front());
                    end
                    if (pending_items.size() > 0 && !pending_items[0].wait_drain) begin
                        next_item  = pending_items.pop_front();
                        next_valid = 1'b1;
                        load       = 1'b1;
                        if (burst_left > 0) begin
                            burst_left--;
                        end else begin
                            burst_left = $urandom_range(0, 15);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        end
                    end
                end
            end
        end
        i_in_valid <= next_valid;
        if (load) begin
            i_command     <= next_item.command;
            i_source_node <= next_item.source_node;
            i_target_node <= next_item.target_node;
        end
    end

    always @(negedge i_clk) begin
        logic stall_next;
        if (stall_mode_left == 0) begin
            stall_mode      = t_stall_mode'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(20, 80);
        end else begin
            stall_mode_left--;
        end
        case (stall_mode)
            STALL_NONE:     stall_next = 1'b0;
            STALL_RANDOM:   stall_next = ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: stall_next = (cycle_count % 3 == 0);
            default: begin
                if (long_stall_left > 0) begin
                    long_stall_left--;
                    stall_next = 1'b1;
                end else if ($urandom_range(0, 7) == 0) begin
                    long_stall_left = $urandom_range(1, 20);
                    stall_next      = 1'b1;
                end else begin
                    stall_next = 1'b0;
                end
            end
        endcase
        i_out_stall <= stall_next;
    end

    initial begin
        int random_count;
        int pick;
        int n_adds;
        int span;
        random_count = 0;
        foreach (reach_rows[r]) reach_rows[r] = '0;

        // Close on the empty graph emits nothing.
        push_item(dtc_pkg::CMD_CLOSE, 0, 0);
        // A self loop, the extreme node ids, a cycle between them and a duplicate edge.
        push_item(dtc_pkg::CMD_ADD, 0, 0);
        push_item(dtc_pkg::CMD_CLOSE, 7, 7);
        push_item(dtc_pkg::CMD_ADD, 7, 7);
        push_item(dtc_pkg::CMD_ADD, 0, 7);
        push_item(dtc_pkg::CMD_ADD, 7, 0);
        push_item(dtc_pkg::CMD_ADD, 0, 7);
        push_item(dtc_pkg::CMD_CLOSE, 0, 0);
        // The unused command is ignored and node fields on a close do not matter.
        push_item(CMD_UNUSED, 5, 3);
        push_item(dtc_pkg::CMD_CLOSE, 7, 7);
        // Clear with node fields set, then close on the emptied graph.
        push_item(dtc_pkg::CMD_CLEAR, 7, 7);
        push_item(dtc_pkg::CMD_CLOSE, 3, 5);
        // A ring through every node closes into the complete graph.
        for (int n = 0; n < dtc_pkg::NODES; n++) begin
            push_item(dtc_pkg::CMD_ADD, n, (n + 1) % dtc_pkg::NODES);
        end
        push_item(dtc_pkg::CMD_CLOSE, 2, 6);
        push_item(dtc_pkg::CMD_CLEAR, 0, 0);
        push_drain_point();

        while (random_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                if ($urandom_range(0, 2) != 0) begin
                    push_item(dtc_pkg::CMD_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7));
                    random_count++;
                end
                n_adds = $urandom_range(1, 10);
                span   = $urandom_range(1, dtc_pkg::NODES - 1);
                for (int a = 0; a < n_adds; a++) begin
                    push_item(dtc_pkg::CMD_ADD, $urandom_range(0, span),
                              $urandom_range(0, span));
                end
                push_item(dtc_pkg::CMD_CLOSE, $urandom_range(0, 7), $urandom_range(0, 7));
                random_count += n_adds + 1;
            end else if (pick == 7) begin
                push_item(CMD_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7));
                random_count++;
            end else if (pick == 8) begin
                push_item(dtc_pkg::CMD_CLOSE, $urandom_range(0, 7), $urandom_range(0, 7));
                random_count++;
            end else begin
                push_item(dtc_pkg::CMD_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7));
                random_count++;
            end
            if ($urandom_range(0, 29) == 0) begin
                push_drain_point();
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (closure_edges_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (closure_edges_due.size() != 0) begin
            report_mismatch($sformatf("%0d expected edges never emitted",
                                      closure_edges_due.size()));
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
src/dtc_pkg.sv
src/dtc_cell.sv
src/dag_transitive_closure_unit.sv
src/dtc_checker.sv
bench/tb_dag_transitive_closure_unit.sv
